[hw/rtl/ttl_kv_pkg.sv]
// ----------------------------------------------------------------------------
// ttl_kv_pkg: shared types and constants of the expiring key/value table
// Holds the command codes and the request and response payload structs.
// ----------------------------------------------------------------------------
package ttl_kv_pkg;

	// Fixed field widths of the request and response payloads.
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 64;
	localparam int VALUE_W  = 64;
	localparam int TIME_W   = 32;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

	// A put with an expiry of zero stores this instead, since zero marks a free slot.
	localparam logic [TIME_W-1:0] EXPIRY_MIN = 32'd1;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0]  expiry;
		logic [TIME_W-1:0]  now;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] value_out;
	} rsp_t;

endpackage

[hw/rtl/ttl_kv_table.sv]
// ----------------------------------------------------------------------------
// ttl_kv_table: key/value table with expiry times and earliest-expiry eviction
// ----------------------------------------------------------------------------
// Each request carries a command (put, get or delete), a key, a value, an
// expiry time and the current time. Every request returns exactly one
// response with a hit flag and the stored value on a get hit.
//
// The table is scanned one slot per cycle through a single compare unit that
// ranks expiry times; a separate comparator checks the key. A request is
// scanned over every slot (the memories have a registered read port), then
// the update step writes the table and loads the response register. The
// block takes no new request until that step has loaded the response.
//
// After reset the block clears the expiry memory one slot at a time, and
// req_stall stays high during that pass. The response sits in its own
// register, so a new request is accepted while the previous response waits.
// When rsp_stall holds the response, the next request finishes its scan and
// then waits until the response register is free.
// ----------------------------------------------------------------------------
module ttl_kv_table #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ttl_kv_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ttl_kv_pkg::rsp_t  rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int TW    = ttl_kv_pkg::TIME_W;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t state_q;

	// Slot memories.
	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];
	logic [TW-1:0]         exp_mem [ENTRIES];

	// Request registers.
	logic [ttl_kv_pkg::CMD_W-1:0] cmd_q;
	logic [KEY_BITS-1:0]          key_q;
	logic [VALUE_BITS-1:0]        val_q;
	logic [TW-1:0]                expiry_q;
	logic [TW-1:0]                now_q;

	// Scan counter and read stage.
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      rd_addr;
	logic                  rd_en;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [KEY_BITS-1:0]   rd_key_s1;
	logic [VALUE_BITS-1:0] rd_val_s1;
	logic [TW-1:0]         rd_exp_s1;

	// Scan results.
	logic                  found_q;
	logic [IDX_W-1:0]      found_idx_q;
	logic [VALUE_BITS-1:0] found_val_q;
	logic [TW-1:0]         found_exp_q;
	logic                  empty_q;
	logic [IDX_W-1:0]      empty_idx_q;
	logic                  vic_q;
	logic [IDX_W-1:0]      vic_idx_q;
	logic [TW-1:0]         vic_exp_q;

	// Shared less-than compare unit.
	logic [TW-1:0] cmp_a;
	logic [TW-1:0] cmp_b;
	logic          cmp_lt;

	// Table update controls.
	logic                  kv_we;
	logic                  exp_we;
	logic [IDX_W-1:0]      wr_addr;
	logic [TW-1:0]         wr_exp;
	logic                  expired;
	logic                  get_hit;
	logic                  rsp_free;
	logic                  req_take;
	logic                  live_s1;
	logic                  match_s1;

	logic                  rsp_valid_q;
	ttl_kv_pkg::rsp_t      rsp_q;

	assign req_take  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Read address walks the slots during the scan.
	assign rd_addr = cnt_q[IDX_W-1:0];
	assign rd_en   = (state_q == S_SCAN) && (cnt_q < CNT_W'(ENTRIES));

	// The compare unit ranks expiries during the scan and checks staleness afterwards.
	always_comb begin
		if (state_q == S_SCAN) begin
			cmp_a = rd_exp_s1;
			cmp_b = vic_exp_q;
		end else begin
			cmp_a = now_q;
			cmp_b = found_exp_q;
		end
		cmp_lt = (cmp_a < cmp_b);
	end

	assign live_s1  = (rd_exp_s1 != '0);
	assign match_s1 = live_s1 && (rd_key_s1 == key_q);

	// An entry is stale on get when now is nonzero and now is not below its expiry.
	assign expired = (now_q != '0) && !cmp_lt;
	assign get_hit = (cmd_q == ttl_kv_pkg::CMD_GET) && found_q && !expired;

	// Table writes: the clearing pass after reset, then the update of one request.
	always_comb begin
		kv_we   = 1'b0;
		exp_we  = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_exp  = '0;
		case (state_q)
			S_CLEAR: begin
				exp_we = 1'b1;
			end
			S_WRITE: begin
				if (rsp_free) begin
					case (cmd_q)
						ttl_kv_pkg::CMD_PUT: begin
							kv_we  = 1'b1;
							exp_we = 1'b1;
							wr_exp = (expiry_q != '0) ? expiry_q : ttl_kv_pkg::EXPIRY_MIN;
							if (found_q) begin
								wr_addr = found_idx_q;
							end else if (empty_q) begin
								wr_addr = empty_idx_q;
							end else begin
								wr_addr = vic_idx_q;
							end
						end
						ttl_kv_pkg::CMD_GET: begin
							exp_we  = found_q && expired;
							wr_addr = found_idx_q;
						end
						ttl_kv_pkg::CMD_DEL: begin
							exp_we  = found_q;
							wr_addr = found_idx_q;
						end
						default: begin
							exp_we = 1'b0;
						end
					endcase
				end
			end
			default: begin
				kv_we = 1'b0;
			end
		endcase
	end

	// Slot memories with a registered read port.
	always_ff @(posedge clk) begin
		if (kv_we) begin
			key_mem[wr_addr] <= key_q;
			val_mem[wr_addr] <= val_q;
		end
		if (exp_we) begin
			exp_mem[wr_addr] <= wr_exp;
		end
		rd_key_s1 <= key_mem[rd_addr];
		rd_val_s1 <= val_mem[rd_addr];
		rd_exp_s1 <= exp_mem[rd_addr];
		rd_idx_s1 <= rd_addr;
	end

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q    <= req.cmd;
			key_q    <= req.key[KEY_BITS-1:0];
			val_q    <= req.value[VALUE_BITS-1:0];
			expiry_q <= req.expiry;
			now_q    <= req.now;
		end
		if (rd_vld_s1) begin
			if (match_s1 && !found_q) begin
				found_idx_q <= rd_idx_s1;
				found_val_q <= rd_val_s1;
				found_exp_q <= rd_exp_s1;
			end
			if (!live_s1 && !empty_q) begin
				empty_idx_q <= rd_idx_s1;
			end
			if (live_s1 && (!vic_q || cmp_lt)) begin
				vic_idx_q <= rd_idx_s1;
				vic_exp_q <= rd_exp_s1;
			end
		end
		if (state_q == S_WRITE && rsp_free) begin
			rsp_q.hit       <= get_hit;
			rsp_q.value_out <= get_hit ? ttl_kv_pkg::VALUE_W'(found_val_q) : '0;
		end
	end

	// Sequencer and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			empty_q     <= 1'b0;
			vic_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (rd_vld_s1) begin
				if (match_s1) begin
					found_q <= 1'b1;
				end
				if (!live_s1) begin
					empty_q <= 1'b1;
				end
				if (live_s1) begin
					vic_q <= 1'b1;
				end
			end
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(ENTRIES - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_take) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						empty_q <= 1'b0;
						vic_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The scan counter never runs past the table.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("scan counter beyond table size");

	// A new response is loaded only by the update step.
	a_rsp_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_WRITE))
		else $error("response raised outside the update step");

	// Only a get can report a hit.
	a_hit_on_get: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) && rsp.hit |-> cmd_q == ttl_kv_pkg::CMD_GET)
		else $error("hit reported for a command other than get");

	// A request is accepted only while no scan is running.
	a_no_take_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == S_SCAN && cnt_q == '0)
		else $error("accepted request did not start a scan");

endmodule
